// ===== design/bgp_pkg.sv =====
package bgp_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int ADC_BITS   = 10;
    localparam int VOLT_W     = 13;
    localparam int PCT_W      = 7;
    localparam int LPCT_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MV      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MV      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS = 2'd2;

    // reset values
    localparam logic [VOLT_W-1:0] MIN_MV_RST      = 13'd3300;
    localparam logic [VOLT_W-1:0] MAX_MV_RST      = 13'd4200;
    localparam logic [TIME_W-1:0] INTERVAL_MS_RST = 32'd30000;
    localparam logic [VOLT_W-1:0] LAST_V_RST      = 13'd999;
    localparam logic [LPCT_W-1:0] LAST_PCT_RST    = 10'd999;

    // curve constants
    localparam int Q_FRAC = 16;
    localparam int X_W    = 17;
    localparam int XP_W   = 21;
    localparam int T_W    = 23;
    localparam logic [VOLT_W-1:0] FULL_SCALE_MV = 13'd4851;
    localparam logic [VOLT_W-1:0] VOLT_MAX      = 13'h1FFF;
    localparam logic [X_W-1:0]    SLOPE_Q16     = 17'd112984;
    localparam logic [PCT_W-1:0]  PCT_FULL      = 7'd100;
    localparam logic [PCT_W-1:0]  PCT_EMPTY     = 7'd0;
    localparam logic [T_W-1:0]    OFFSET_Q16    = 23'(105 * 65536);

    // bit-serial multiplier
    localparam int MUL_AW = 21;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW);

    // restoring divider
    localparam int DIV_NW = 39;
    localparam int DIV_DW = 22;
    localparam int DIV_CW = $clog2(DIV_NW);
    localparam logic [DIV_NW-1:0] DIV_T_NUM = 39'(105) << 32;
    localparam logic [DIV_DW-1:0] Q16_ONE   = 22'(65536);

    // square root, two radicand bits per step
    localparam int SQ_RW    = 34;
    localparam int SQ_QW    = SQ_RW / 2;
    localparam int SQ_MW    = SQ_QW + 2;
    localparam int SQ_TW    = SQ_MW + 2;
    localparam int SQ_CW    = $clog2(SQ_QW);

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [ADC_BITS-1:0] adc_sample;
    } t_in;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [PCT_W-1:0]  percent;
    } t_out;

endpackage

// ===== design/bgp_mul.sv =====
module bgp_mul
    import bgp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_AW-1:0] i_a,
    input  logic [MUL_BW-1:0] i_b,
    output logic [MUL_PW-1:0] o_prod,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [MUL_CW-1:0] r_cnt;
    logic [MUL_PW-1:0] r_acc;
    logic [MUL_PW-1:0] r_a;
    logic [MUL_BW-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CW'(MUL_BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= MUL_PW'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= r_acc + (r_b[0] ? r_a : '0);
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
        end
    end

    assign o_prod = r_acc;
    assign o_done = r_done;

endmodule

// ===== design/bgp_div.sv =====
module bgp_div
    import bgp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   w_trial;
    logic              n_bit;
    logic [DIV_DW-1:0] n_rem;

    // shift in the next dividend bit and subtract where it fits
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_NW-1]};
        n_bit   = (w_trial >= {1'b0, r_den});
        n_rem   = n_bit ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NW-2:0], n_bit};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// ===== design/bgp_sqrt.sv =====
module bgp_sqrt
    import bgp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_RW-1:0] i_rad,
    output logic [SQ_QW-1:0] o_root,
    output logic             o_done
);

    logic             r_busy;
    logic             r_done;
    logic [SQ_CW-1:0] r_cnt;
    logic [SQ_RW-1:0] r_rad;
    logic [SQ_MW-1:0] r_rem;
    logic [SQ_QW-1:0] r_root;

    logic [SQ_TW-1:0] w_cur;
    logic [SQ_TW-1:0] w_trial;
    logic             n_bit;
    logic [SQ_MW-1:0] n_rem;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        w_cur   = {r_rem, r_rad[SQ_RW-1 -: 2]};
        w_trial = SQ_TW'({r_root, 2'b01});
        n_bit   = (w_cur >= w_trial);
        n_rem   = n_bit ? SQ_MW'(w_cur - w_trial) : w_cur[SQ_MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_CW'(SQ_QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= {r_root[SQ_QW-2:0], n_bit};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== design/battery_gauge_percent.sv =====
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in: now_ms, adc_sample)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out: voltage_mv, percent)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A poll inside the interval is dropped in its accept cycle. An accepted poll runs one
// multiply when the voltage is at or beyond a threshold and, on the curve, seven
// 17-step multiplies, two 39-step divides and one 17-step root, run one at a time on
// the bit-serial units, each started by the registered go strobe after the last is done.
// Reset is synchronous, active low, and clears all control state at once.
// A waiting result holds in the output register; the next poll is taken meanwhile and
// the sequencer stalls only when it has a new result and the register is still full.
module battery_gauge_percent
    import bgp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MV   = 4'd1;
    localparam logic [3:0] ST_CMP  = 4'd2;
    localparam logic [3:0] ST_MD   = 4'd3;
    localparam logic [3:0] ST_DX   = 4'd4;
    localparam logic [3:0] ST_X2   = 4'd5;
    localparam logic [3:0] ST_X3   = 4'd6;
    localparam logic [3:0] ST_X4   = 4'd7;
    localparam logic [3:0] ST_X5   = 4'd8;
    localparam logic [3:0] ST_SQ   = 4'd9;
    localparam logic [3:0] ST_PM   = 4'd10;
    localparam logic [3:0] ST_DT   = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    logic [VOLT_W-1:0]   r_min;
    logic [VOLT_W-1:0]   r_max;
    logic [TIME_W-1:0]   r_interval;
    logic [TIME_W-1:0]   r_last_time;
    logic [VOLT_W-1:0]   r_last_v;
    logic [LPCT_W-1:0]   r_last_pct;

    logic [3:0]          r_state;
    logic                r_go;
    logic [ADC_BITS-1:0] r_sample;
    logic [VOLT_W-1:0]   r_v;
    logic [X_W-1:0]      r_x;
    logic [XP_W-1:0]     r_xp;
    logic [SQ_QW-1:0]    r_s;
    logic [PCT_W-1:0]    r_pct;
    logic                r_out_valid;
    t_out                r_out;

    logic                w_in_acc;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_skip;
    logic                w_changed;
    logic                w_out_free;
    logic [VOLT_W-1:0]   w_mv;
    logic [T_W-1:0]      w_rem_pct;
    logic [PCT_W-1:0]    w_pct;

    logic                mul_start;
    logic [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]   mul_b;
    logic [MUL_PW-1:0]   mul_prod;
    logic                mul_done;
    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic [DIV_NW-1:0]   div_quo;
    logic                div_done;
    logic                sq_start;
    logic [SQ_QW-1:0]    sq_root;
    logic                sq_done;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_elapsed  = i_in_data.now_ms - r_last_time;
    assign w_skip     = (r_last_time != '0) && (w_elapsed < r_interval);
    assign w_changed  = (r_v != r_last_v) || (LPCT_W'(r_pct) != r_last_pct);
    assign w_out_free = !r_out_valid || i_out_ready;

    // millivolts from the product, saturated to the field
    assign w_mv = (|mul_prod[MUL_PW-1:ADC_BITS+VOLT_W]) ? VOLT_MAX
                                                        : mul_prod[ADC_BITS +: VOLT_W];

    // 105 - 105/(1+x^5.5), integer part, capped at full
    assign w_rem_pct = OFFSET_Q16 - div_quo[T_W-1:0];
    assign w_pct     = (w_rem_pct[T_W-1:Q_FRAC] >= PCT_FULL) ? PCT_FULL
                                                             : w_rem_pct[T_W-1:Q_FRAC];

    // operand steering for the shared units
    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_xp;
        mul_b     = MUL_BW'(r_x);
        div_start = 1'b0;
        div_num   = DIV_NW'(mul_prod);
        div_den   = DIV_DW'(r_max - r_min);
        sq_start  = 1'b0;
        case (r_state)
            ST_MV: begin
                mul_start = r_go;
                mul_a     = MUL_AW'(FULL_SCALE_MV);
                mul_b     = MUL_BW'(r_sample);
            end
            ST_MD: begin
                mul_start = r_go;
                mul_a     = MUL_AW'(SLOPE_Q16);
                mul_b     = MUL_BW'(r_v - r_min);
            end
            ST_X2: begin
                mul_start = r_go;
                mul_a     = MUL_AW'(r_x);
            end
            ST_X3, ST_X4, ST_X5: begin
                mul_start = r_go;
            end
            ST_PM: begin
                mul_start = r_go;
                mul_b     = MUL_BW'(r_s);
            end
            ST_DX: begin
                div_start = r_go;
            end
            ST_DT: begin
                div_start = r_go;
                div_num   = DIV_T_NUM;
                div_den   = Q16_ONE + mul_prod[MUL_PW-1:Q_FRAC];
            end
            ST_SQ: begin
                sq_start = r_go;
            end
            default: begin
            end
        endcase
    end

    bgp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_done  (mul_done)
    );

    bgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    bgp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   ({1'b0, r_x, 16'b0}),
        .o_root  (sq_root),
        .o_done  (sq_done)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min      <= MIN_MV_RST;
            r_max      <= MAX_MV_RST;
            r_interval <= INTERVAL_MS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_MV:      r_min      <= i_cfg_data[VOLT_W-1:0];
                CFG_MAX_MV:      r_max      <= i_cfg_data[VOLT_W-1:0];
                CFG_INTERVAL_MS: r_interval <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_last_time <= '0;
            r_last_v    <= LAST_V_RST;
            r_last_pct  <= LAST_PCT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && !w_skip) begin
                        r_last_time <= i_in_data.now_ms;
                        r_state     <= ST_MV;
                        r_go        <= 1'b1;
                    end
                end
                ST_MV: begin
                    if (mul_done) begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (r_v <= r_min) begin
                        r_state <= ST_FIN;
                    end else if (r_v >= r_max) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_MD;
                        r_go    <= 1'b1;
                    end
                end
                ST_MD: begin
                    if (mul_done) begin
                        r_state <= ST_DX;
                        r_go    <= 1'b1;
                    end
                end
                ST_DX: begin
                    if (div_done) begin
                        r_state <= ST_X2;
                        r_go    <= 1'b1;
                    end
                end
                ST_X2: begin
                    if (mul_done) begin
                        r_state <= ST_X3;
                        r_go    <= 1'b1;
                    end
                end
                ST_X3: begin
                    if (mul_done) begin
                        r_state <= ST_X4;
                        r_go    <= 1'b1;
                    end
                end
                ST_X4: begin
                    if (mul_done) begin
                        r_state <= ST_X5;
                        r_go    <= 1'b1;
                    end
                end
                ST_X5: begin
                    if (mul_done) begin
                        r_state <= ST_SQ;
                        r_go    <= 1'b1;
                    end
                end
                ST_SQ: begin
                    if (sq_done) begin
                        r_state <= ST_PM;
                        r_go    <= 1'b1;
                    end
                end
                ST_PM: begin
                    if (mul_done) begin
                        r_state <= ST_DT;
                        r_go    <= 1'b1;
                    end
                end
                ST_DT: begin
                    if (div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // report only a change; hold while the output register is full
                    if (!w_changed) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_last_v    <= r_v;
                        r_last_pct  <= LPCT_W'(r_pct);
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_in_data.adc_sample;
        end
        if (r_state == ST_MV && mul_done) begin
            r_v <= w_mv;
        end
        if (r_state == ST_CMP) begin
            r_pct <= (r_v <= r_min) ? PCT_EMPTY : PCT_FULL;
        end
        if (r_state == ST_DX && div_done) begin
            r_x <= div_quo[X_W-1:0];
        end
        if ((r_state == ST_X2 || r_state == ST_X3 || r_state == ST_X4 || r_state == ST_X5)
            && mul_done) begin
            r_xp <= mul_prod[Q_FRAC +: XP_W];
        end
        if (r_state == ST_SQ && sq_done) begin
            r_s <= sq_root;
        end
        if (r_state == ST_DT && div_done) begin
            r_pct <= w_pct;
        end
        if (r_state == ST_FIN && w_changed && w_out_free) begin
            r_out.voltage_mv <= r_v;
            r_out.percent    <= r_pct;
        end
    end

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.percent <= PCT_FULL))
        else $error("percent above full");

    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.voltage_mv == r_last_v)
                        && (LPCT_W'(o_out_data.percent) == r_last_pct))
        else $error("pending result differs from stored last values");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MV || r_state == ST_MD || r_state == ST_X2
                      || r_state == ST_X3 || r_state == ST_X4 || r_state == ST_X5
                      || r_state == ST_PM))
        else $error("multiplier finished with no step waiting");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DX || r_state == ST_DT))
        else $error("divider finished with no step waiting");

    a_sqrt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == ST_SQ))
        else $error("square root finished with no step waiting");

endmodule
